### design/lru_tag_cache_with_stats_top_defines.svh
// Assertion macros shared by the checker of the tag cache.
`ifndef LRU_TAG_CACHE_WITH_STATS_TOP_DEFINES_SVH
`define LRU_TAG_CACHE_WITH_STATS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define LTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define LTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ltc_pkg.sv
// Shared types and codes of the tag cache.
`default_nettype none
package ltc_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STATS  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_FILLED = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_FAILED = 3'd3;
  localparam logic [2:0] ST_STATS  = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;

  // Command broadcast to every cell; idx selects the target.
  typedef struct packed {
    logic wr;       // fill target with key and stamp
    logic touch;    // refresh target stamp
    logic clr;      // empty target
    logic shift;    // move valid/asset one cell toward the end, clear rest
  } cmd_t;

  // Search token flags traveling down the chain.
  typedef struct packed {
    logic active;
    logic found;
    logic free;
    logic have_min;
  } tok_t;

endpackage
`default_nettype wire

### design/ltc_cell.sv
// One cache slot: tag, stamp, and one stage of the search token.
`default_nettype none
module ltc_cell #(
  parameter int IDX_W   = 5,
  parameter int KEY_W   = 4,
  parameter int VAR_W   = 16,
  parameter int SIZE_W  = 12,
  parameter int STAMP_W = 32,
  parameter int INDEX   = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ltc_pkg::cmd_t        cmd,
  input  wire logic [IDX_W-1:0]     cmd_idx,
  input  wire logic [STAMP_W-1:0]   wr_stamp,
  input  wire logic [KEY_W-1:0]     key_asset,
  input  wire logic [VAR_W-1:0]     key_var,
  input  wire logic [SIZE_W-1:0]    key_w,
  input  wire logic [SIZE_W-1:0]    key_h,
  input  wire logic                 prev_valid,
  input  wire logic [KEY_W-1:0]     prev_asset,
  output logic                      cur_valid,
  output logic [KEY_W-1:0]          cur_asset,
  input  wire ltc_pkg::tok_t        tok_in,
  input  wire logic [IDX_W-1:0]     fidx_in,
  input  wire logic [IDX_W-1:0]     free_in,
  input  wire logic [STAMP_W-1:0]   mstamp_in,
  input  wire logic [IDX_W-1:0]     midx_in,
  input  wire logic [KEY_W-1:0]     masset_in,
  output ltc_pkg::tok_t             tok_out,
  output logic [IDX_W-1:0]          fidx_out,
  output logic [IDX_W-1:0]          free_out,
  output logic [STAMP_W-1:0]        mstamp_out,
  output logic [IDX_W-1:0]          midx_out,
  output logic [KEY_W-1:0]          masset_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                valid;
  logic [KEY_W-1:0]    asset;
  logic [VAR_W-1:0]    var_tag;
  logic [SIZE_W-1:0]   w_tag;
  logic [SIZE_W-1:0]   h_tag;
  logic [STAMP_W-1:0]  stamp;
  logic                sel;
  logic                match;
  ltc_pkg::tok_t       tok_next;
  logic [IDX_W-1:0]    fidx_next;
  logic [IDX_W-1:0]    free_next;
  logic [STAMP_W-1:0]  mstamp_next;
  logic [IDX_W-1:0]    midx_next;
  logic [KEY_W-1:0]    masset_next;

  assign sel       = (cmd_idx == MY_IDX);
  assign cur_valid = valid;
  assign cur_asset = asset;
  assign match     = valid && asset == key_asset && var_tag == key_var &&
                     w_tag == key_w && h_tag == key_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      asset   <= '0;
      var_tag <= '0;
      w_tag   <= '0;
      h_tag   <= '0;
      stamp   <= '0;
    end else if (cmd.shift) begin
      valid   <= prev_valid;
      asset   <= prev_asset;
      var_tag <= '0;
      w_tag   <= '0;
      h_tag   <= '0;
      stamp   <= '0;
    end else if (sel && cmd.wr) begin
      valid   <= 1'b1;
      asset   <= key_asset;
      var_tag <= key_var;
      w_tag   <= key_w;
      h_tag   <= key_h;
      stamp   <= wr_stamp;
    end else if (sel && cmd.clr) begin
      valid   <= 1'b0;
      asset   <= '0;
      var_tag <= '0;
      w_tag   <= '0;
      h_tag   <= '0;
      stamp   <= '0;
    end else if (sel && cmd.touch) begin
      stamp   <= wr_stamp;
    end
  end

  // Fold this slot into the running search result.
  always_comb begin
    tok_next    = tok_in;
    fidx_next   = fidx_in;
    free_next   = free_in;
    mstamp_next = mstamp_in;
    midx_next   = midx_in;
    masset_next = masset_in;
    if (!tok_in.found && match) begin
      tok_next.found = 1'b1;
      fidx_next      = MY_IDX;
    end
    if (!tok_in.free && !valid) begin
      tok_next.free = 1'b1;
      free_next     = MY_IDX;
    end
    if (valid && (!tok_in.have_min || stamp < mstamp_in)) begin
      tok_next.have_min = 1'b1;
      mstamp_next       = stamp;
      midx_next         = MY_IDX;
      masset_next       = asset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    fidx_out   <= fidx_next;
    free_out   <= free_next;
    mstamp_out <= mstamp_next;
    midx_out   <= midx_next;
    masset_out <= masset_next;
  end

endmodule
`default_nettype wire

### design/lru_tag_cache_with_stats_top.sv
// Top level of the fully associative LRU tag cache with per-asset counters.
//
//   channel | direction | handshake          | beat carries
//   --------+-----------+--------------------+-------------------------------------
//   in      | to block  | in_valid/in_stall  | opcode, asset_id, variant_id, size
//   out     | from block| out_valid/out_stall| status, slot, eviction, four counters
//
// A lookup's accepted beat sets the launch register, which starts the search token
// walking the chain of slot cells one cell per cycle; the apply state then makes
// the update and loads the result, waiting while a stalled result holds the output
// register, and the next beat is taken back in idle. A flush shifts every slot out
// of the chain end to count its release, then loads its result. Stats reads and
// rejected beats answer at the accepting edge and can run back to back.
// Reset (rst, synchronous) empties all slots, zeroes the use stamp and every
// counter. A stalled result holds in the output register; the next lookup or
// flush still runs while it waits, while stats reads and rejected beats stall.
`default_nettype none
module lru_tag_cache_with_stats_top #(
  parameter int ENTRIES      = 32,
  parameter int KEYS         = 16,
  parameter int VARIANT_BITS = 16,
  parameter int SIZE_BITS    = 12,
  parameter int STAMP_BITS   = 32,
  localparam int IDX_W       = $clog2(ENTRIES),
  localparam int KEY_W       = (KEYS > 1) ? $clog2(KEYS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       opcode,
  input  wire logic [7:0]       asset_id,
  input  wire logic [15:0]      variant_id,
  input  wire logic [11:0]      width,
  input  wire logic [11:0]      height,
  input  wire logic             fill_ok,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            status,
  output logic [IDX_W-1:0]      slot,
  output logic                  evicted,
  output logic [KEY_W-1:0]      evicted_asset,
  output logic [31:0]           hit_total,
  output logic [31:0]           build_total,
  output logic [31:0]           alloc_total,
  output logic [31:0]           release_total
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_APPLY = 5'b00100,
    S_FLUSH = 5'b01000,
    S_FDONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // Latched request.
  logic [KEY_W-1:0]      req_asset;
  logic [VARIANT_BITS-1:0] req_var;
  logic [SIZE_BITS-1:0]  req_w;
  logic [SIZE_BITS-1:0]  req_h;
  logic                  req_ok;
  logic                  launch;

  // Search outcome latched when the token leaves the chain.
  logic                  d_found;
  logic [IDX_W-1:0]      d_fidx;
  logic                  d_evict;
  logic [IDX_W-1:0]      d_pick;
  logic [KEY_W-1:0]      d_ev_asset;

  logic [STAMP_BITS-1:0] use_stamp;
  logic [STAMP_BITS-1:0] stamp_inc;
  logic [STAMP_BITS-1:0] stamp_next;
  logic [IDX_W-1:0]      cnt;

  logic [31:0] hit_counts     [KEYS];
  logic [31:0] build_counts   [KEYS];
  logic [31:0] alloc_counts   [KEYS];
  logic [31:0] release_counts [KEYS];

  // Chain wiring: position i feeds cell i.
  ltc_pkg::tok_t         tok_c    [ENTRIES+1];
  logic [IDX_W-1:0]      fidx_c   [ENTRIES+1];
  logic [IDX_W-1:0]      free_c   [ENTRIES+1];
  logic [STAMP_BITS-1:0] mstamp_c [ENTRIES+1];
  logic [IDX_W-1:0]      midx_c   [ENTRIES+1];
  logic [KEY_W-1:0]      masset_c [ENTRIES+1];
  logic                  v_c      [ENTRIES+1];
  logic [KEY_W-1:0]      a_c      [ENTRIES+1];

  ltc_pkg::cmd_t         cmd;
  logic [IDX_W-1:0]      cmd_idx;

  logic [31:0]           var_ext;
  logic [15:0]           w_ext;
  logic [15:0]           h_ext;
  logic                  key_ok;
  logic                  size_ok;
  logic [KEY_W-1:0]      in_asset;
  logic                  out_free;
  logic                  accept;

  // Counter update requests.
  logic                  hit_inc;
  logic                  fill_inc;
  logic                  rel_inc;
  logic [KEY_W-1:0]      rel_idx;

  // Next contents of the output register.
  logic [2:0]            status_next;
  logic [IDX_W-1:0]      slot_next;
  logic                  evicted_next;
  logic [KEY_W-1:0]      evicted_asset_next;
  logic [31:0]           hit_total_next;
  logic [31:0]           build_total_next;
  logic [31:0]           alloc_total_next;
  logic [31:0]           release_total_next;

  assign var_ext  = 32'(variant_id);
  assign w_ext    = 16'(width);
  assign h_ext    = 16'(height);
  assign in_asset = asset_id[KEY_W-1:0];
  assign key_ok   = {1'b0, asset_id} < 9'(KEYS);
  assign size_ok  = (w_ext[SIZE_BITS-1:0] != '0) && (h_ext[SIZE_BITS-1:0] != '0);
  assign out_free = !out_valid || !out_stall;
  // Lookups with a valid key and size, and flushes, answer later, so they start even while a result waits.
  assign in_stall = !(state == S_IDLE &&
                      (out_free || (opcode == ltc_pkg::OP_LOOKUP && key_ok && size_ok) ||
                       opcode == ltc_pkg::OP_FLUSH));
  assign accept   = in_valid && !in_stall;

  assign stamp_inc  = use_stamp + 1'b1;
  assign stamp_next = (stamp_inc == '0) ? STAMP_BITS'(1) : stamp_inc;

  // Launch token: empty search result entering cell 0.
  assign tok_c[0]    = '{active: launch, found: 1'b0, free: 1'b0, have_min: 1'b0};
  assign fidx_c[0]   = '0;
  assign free_c[0]   = '0;
  assign mstamp_c[0] = '0;
  assign midx_c[0]   = '0;
  assign masset_c[0] = '0;
  assign v_c[0]      = 1'b0;
  assign a_c[0]      = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ltc_cell #(
      .IDX_W(IDX_W), .KEY_W(KEY_W), .VAR_W(VARIANT_BITS),
      .SIZE_W(SIZE_BITS), .STAMP_W(STAMP_BITS), .INDEX(i)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .cmd_idx(cmd_idx), .wr_stamp(stamp_next),
      .key_asset(req_asset), .key_var(req_var), .key_w(req_w), .key_h(req_h),
      .prev_valid(v_c[i]), .prev_asset(a_c[i]),
      .cur_valid(v_c[i+1]), .cur_asset(a_c[i+1]),
      .tok_in(tok_c[i]), .fidx_in(fidx_c[i]), .free_in(free_c[i]),
      .mstamp_in(mstamp_c[i]), .midx_in(midx_c[i]), .masset_in(masset_c[i]),
      .tok_out(tok_c[i+1]), .fidx_out(fidx_c[i+1]), .free_out(free_c[i+1]),
      .mstamp_out(mstamp_c[i+1]), .midx_out(midx_c[i+1]), .masset_out(masset_c[i+1])
    );
  end

  // Sequencer: pick the state, command the cells, request counter bumps.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_idx    = '0;
    hit_inc    = 1'b0;
    fill_inc   = 1'b0;
    rel_inc    = 1'b0;
    rel_idx    = '0;
    case (state)
      S_IDLE: begin
        if (accept && opcode == ltc_pkg::OP_LOOKUP && key_ok && size_ok) begin
          state_next = S_WALK;
        end else if (accept && opcode == ltc_pkg::OP_FLUSH) begin
          state_next = S_FLUSH;
        end
      end
      S_WALK: begin
        if (tok_c[ENTRIES].active) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
          if (d_found) begin
            hit_inc    = 1'b1;
            cmd.touch  = 1'b1;
            cmd_idx    = d_fidx;
          end else begin
            cmd_idx  = d_pick;
            rel_inc  = d_evict;
            rel_idx  = d_ev_asset;
            cmd.wr   = req_ok;
            cmd.clr  = !req_ok;
            fill_inc = req_ok;
          end
        end
      end
      S_FLUSH: begin
        // Count the slot leaving the chain end, then shift.
        cmd.shift = 1'b1;
        rel_inc   = v_c[ENTRIES];
        rel_idx   = a_c[ENTRIES];
        if (cnt == IDX_W'(ENTRIES - 1)) begin
          state_next = S_FDONE;
        end
      end
      S_FDONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      cnt       <= '0;
      use_stamp <= '0;
    end else begin
      state  <= state_next;
      launch <= (state == S_IDLE) && (state_next == S_WALK);
      cnt    <= (state == S_FLUSH) ? cnt + 1'b1 : '0;
      if (state == S_APPLY && out_free && (d_found || req_ok)) begin
        use_stamp <= stamp_next;
      end else if (state == S_FDONE && out_free) begin
        use_stamp <= '0;
      end
    end
  end

  // Hold the request key for the walk and the fill.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_asset <= in_asset;
      req_var   <= var_ext[VARIANT_BITS-1:0];
      req_w     <= w_ext[SIZE_BITS-1:0];
      req_h     <= h_ext[SIZE_BITS-1:0];
      req_ok    <= fill_ok;
    end
    if (state == S_WALK && tok_c[ENTRIES].active) begin
      d_found    <= tok_c[ENTRIES].found;
      d_fidx     <= fidx_c[ENTRIES];
      d_evict    <= !tok_c[ENTRIES].free;
      d_pick     <= tok_c[ENTRIES].free ? free_c[ENTRIES] : midx_c[ENTRIES];
      d_ev_asset <= tok_c[ENTRIES].free ? '0 : masset_c[ENTRIES];
    end
  end

  // Per-asset counters, all wrapping at 2^32.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEYS; k++) begin
        hit_counts[k]     <= '0;
        build_counts[k]   <= '0;
        alloc_counts[k]   <= '0;
        release_counts[k] <= '0;
      end
    end else begin
      if (hit_inc) begin
        hit_counts[req_asset] <= hit_counts[req_asset] + 1'b1;
      end
      if (fill_inc) begin
        build_counts[req_asset] <= build_counts[req_asset] + 1'b1;
        alloc_counts[req_asset] <= alloc_counts[req_asset] + 1'b1;
      end
      if (rel_inc) begin
        release_counts[rel_idx] <= release_counts[rel_idx] + 1'b1;
      end
    end
  end

  // Output register: load a beat when one is ready, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_IDLE && accept &&
                    !(opcode == ltc_pkg::OP_LOOKUP && key_ok && size_ok) &&
                    opcode != ltc_pkg::OP_FLUSH) ||
                   state == S_APPLY || state == S_FDONE;
    end
  end

  // Build the result beat for the current state.
  always_comb begin
    status_next        = ltc_pkg::ST_REJECT;
    slot_next          = '0;
    evicted_next       = 1'b0;
    evicted_asset_next = '0;
    hit_total_next     = '0;
    build_total_next   = '0;
    alloc_total_next   = '0;
    release_total_next = '0;
    case (state)
      S_IDLE: begin
        if (opcode == ltc_pkg::OP_STATS) begin
          status_next = ltc_pkg::ST_STATS;
          if (key_ok) begin
            hit_total_next     = hit_counts[in_asset];
            build_total_next   = build_counts[in_asset];
            alloc_total_next   = alloc_counts[in_asset];
            release_total_next = release_counts[in_asset];
          end
        end
      end
      S_APPLY: begin
        if (d_found) begin
          status_next = ltc_pkg::ST_HIT;
          slot_next   = d_fidx;
        end else begin
          status_next        = req_ok ? ltc_pkg::ST_FILLED : ltc_pkg::ST_FAILED;
          slot_next          = d_pick;
          evicted_next       = d_evict;
          evicted_asset_next = d_ev_asset;
        end
      end
      S_FDONE: begin
        status_next = ltc_pkg::ST_FLUSH;
      end
      default: begin
        status_next = ltc_pkg::ST_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      status        <= status_next;
      slot          <= slot_next;
      evicted       <= evicted_next;
      evicted_asset <= evicted_asset_next;
      hit_total     <= hit_total_next;
      build_total   <= build_total_next;
      alloc_total   <= alloc_total_next;
      release_total <= release_total_next;
    end
  end

endmodule
`default_nettype wire

### design/ltc_checker.sv
// Port-level checker for the tag cache, bound to the top level.
`default_nettype none
`include "lru_tag_cache_with_stats_top_defines.svh"
module ltc_checker #(
  parameter int IDX_W = 5,
  parameter int KEY_W = 4
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [2:0]       status,
  input wire logic [IDX_W-1:0] slot,
  input wire logic             evicted,
  input wire logic [KEY_W-1:0] evicted_asset
);

  logic quiet_beat;

  // Beats that never name a slot: rejects, flushes and stats reads.
  assign quiet_beat = out_valid && (status == ltc_pkg::ST_REJECT ||
                                    status == ltc_pkg::ST_FLUSH ||
                                    status == ltc_pkg::ST_STATS);

  `LTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat dropped")
  `LTC_ASSERT_NOW(a_status_code, out_valid, status <= ltc_pkg::ST_FLUSH, "status out of range")
  `LTC_ASSERT_NOW(a_idle_result, quiet_beat, slot == '0 && !evicted, "slot on non-lookup beat")
  `LTC_ASSERT_NOW(a_evict_asset, out_valid && !evicted, evicted_asset == '0, "asset without eviction")

endmodule

bind lru_tag_cache_with_stats_top ltc_checker #(.IDX_W(IDX_W), .KEY_W(KEY_W)) u_ltc_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .slot(slot), .evicted(evicted), .evicted_asset(evicted_asset)
);
`default_nettype wire
